FILE: rtl/rdiv_pkg.sv
// Package with the shared types and action codes of the pipelined restoring divider.
`default_nettype none

package rdiv_pkg;

    // Action codes of an input item.
    localparam logic ACT_UNSIGNED = 1'b0;
    localparam logic ACT_SIGNED   = 1'b1;

    // Sign fix-up that travels with an item down the pipeline.
    typedef struct packed {
        logic neg_q;    // negate the magnitude quotient
        logic neg_r;    // negate a nonzero magnitude remainder
    } t_rdiv_ctl;

endpackage

`default_nettype wire

FILE: rtl/rdiv_if.sv
// Valid/ready channel interfaces for the divider's operand and result items.
`default_nettype none

interface rdiv_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;

    modport source (output valid, action, dividend, divisor, input ready);
    modport sink   (input valid, action, dividend, divisor, output ready);
endinterface

interface rdiv_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;

    modport source (output valid, quotient, remainder, input ready);
    modport sink   (input valid, quotient, remainder, output ready);
endinterface

`default_nettype wire

FILE: rtl/rdiv_prep.sv
// Input stage: takes operand magnitudes and works out the sign fix-up.
`default_nettype none

module rdiv_prep #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic                  i_action,
    input  wire logic [DATA_WIDTH-1:0] i_dividend,
    input  wire logic [DATA_WIDTH-1:0] i_divisor,
    output logic                       o_valid,
    output logic [DATA_WIDTH-1:0]      o_num,
    output logic [DATA_WIDTH-1:0]      o_den,
    output rdiv_pkg::t_rdiv_ctl        o_ctl
);
    import rdiv_pkg::*;

    localparam logic [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

    logic                  is_signed;
    logic                  sign_n;
    logic                  sign_d;
    logic [DATA_WIDTH-1:0] n_num;
    logic [DATA_WIDTH-1:0] n_den;
    t_rdiv_ctl             n_ctl;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_den;
    t_rdiv_ctl             r_ctl;

    always_comb begin
        is_signed   = (i_action == ACT_SIGNED);
        sign_n      = is_signed & i_dividend[DATA_WIDTH-1];
        sign_d      = is_signed & i_divisor[DATA_WIDTH-1];
        n_num       = sign_n ? (~i_dividend) + ONE : i_dividend;
        n_den       = sign_d ? (~i_divisor) + ONE : i_divisor;
        n_ctl.neg_q = sign_n ^ sign_d;
        n_ctl.neg_r = sign_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_den <= n_den;
            r_ctl <= n_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_ctl   = r_ctl;

endmodule

`default_nettype wire

FILE: rtl/rdiv_step.sv
// One registered restoring step: shift, trial subtract, keep or restore.
`default_nettype none

module rdiv_step #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire logic [DATA_WIDTH-1:0] i_nq,
    input  wire logic [DATA_WIDTH-1:0] i_den,
    input  wire rdiv_pkg::t_rdiv_ctl   i_ctl,
    output logic                       o_valid,
    output logic [DATA_WIDTH-1:0]      o_rem,
    output logic [DATA_WIDTH-1:0]      o_nq,
    output logic [DATA_WIDTH-1:0]      o_den,
    output rdiv_pkg::t_rdiv_ctl        o_ctl
);
    import rdiv_pkg::*;

    // The partial remainder is one bit wider than the word after the shift, so the
    // bit shifted out counts in the compare. The low word holds the dividend bits
    // still to come, with quotient bits entering from the bottom.
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  q_bit;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_nq;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_nq;
    logic [DATA_WIDTH-1:0] r_den;
    t_rdiv_ctl             r_ctl;

    always_comb begin
        trial = {i_rem, i_nq[DATA_WIDTH-1]};
        diff  = trial - {1'b0, i_den};
        q_bit = ~diff[DATA_WIDTH];
        n_rem = q_bit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        n_nq  = {i_nq[DATA_WIDTH-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_den <= i_den;
            r_ctl <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_den   = r_den;
    assign o_ctl   = r_ctl;

endmodule

`default_nettype wire

FILE: rtl/rdiv_fix.sv
// Output stage: sign fix-up of the result, output register and skid register.
`default_nettype none

module rdiv_fix #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [DATA_WIDTH-1:0] i_quot,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire rdiv_pkg::t_rdiv_ctl   i_ctl,
    input  wire logic                  i_out_ready,
    output logic                       o_en,
    output logic                       o_out_valid,
    output logic [DATA_WIDTH-1:0]      o_quotient,
    output logic [DATA_WIDTH-1:0]      o_remainder
);
    import rdiv_pkg::*;

    localparam logic [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

    logic                  take;
    logic [DATA_WIDTH-1:0] fix_q;
    logic [DATA_WIDTH-1:0] fix_r;

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_q;
    logic [DATA_WIDTH-1:0] r_out_r;
    logic                  r_skid_valid;
    logic [DATA_WIDTH-1:0] r_skid_q;
    logic [DATA_WIDTH-1:0] r_skid_r;

    // The pipeline moves whenever the skid register is empty.
    assign o_en = ~r_skid_valid;
    assign take = i_valid & ~r_skid_valid;

    always_comb begin
        fix_q = i_ctl.neg_q ? (~i_quot) + ONE : i_quot;
        fix_r = (i_ctl.neg_r && (i_rem != '0)) ? (~i_rem) + ONE : i_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= take;
            end
        end else if (take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_q <= r_skid_q;
                r_out_r <= r_skid_r;
            end else begin
                r_out_q <= fix_q;
                r_out_r <= fix_r;
            end
        end else if (take) begin
            r_skid_q <= fix_q;
            r_skid_r <= fix_r;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_quotient  = r_out_q;
    assign o_remainder = r_out_r;

endmodule

`default_nettype wire

FILE: rtl/restoring_divider_signed_unsigned_top.sv
// Top level of the pipelined signed and unsigned restoring divider.
//
// Operand items arrive on i_in (action, dividend, divisor) and result items
// leave on o_out (quotient, remainder); both are valid/ready channels and an
// item moves at a rising edge with valid and ready high.
// Action selects an unsigned divide or a two's complement divide. In signed
// mode the quotient is negated when the operand signs differ and a nonzero
// remainder takes the dividend's sign. Division by zero gives an all-ones
// magnitude quotient and the dividend's magnitude as remainder, then the
// same sign fix-up.
// The pipeline is one magnitude stage, DATA_WIDTH restoring-step stages of one
// subtract each, and the output register. One item is accepted in every cycle
// while results are taken.
// When the receiver stalls, one more result is caught in a skid register; then
// i_in.ready drops and the whole pipeline holds until the output is taken.
// Reset clears every valid bit; the block takes an item in the first cycle
// after reset.
`default_nettype none

module restoring_divider_signed_unsigned_top #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rdiv_in_if.sink   i_in,
    rdiv_out_if.source o_out
);
    import rdiv_pkg::*;

    logic                  en;
    logic                  st_valid [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] st_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] st_nq    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] st_den   [0:DATA_WIDTH];
    t_rdiv_ctl             st_ctl   [0:DATA_WIDTH];

    assign i_in.ready = en;

    rdiv_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in.valid),
        .i_action   (i_in.action),
        .i_dividend (i_in.dividend),
        .i_divisor  (i_in.divisor),
        .o_valid    (st_valid[0]),
        .o_num      (st_nq[0]),
        .o_den      (st_den[0]),
        .o_ctl      (st_ctl[0])
    );

    assign st_rem[0] = '0;

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
        rdiv_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (st_valid[g]),
            .i_rem   (st_rem[g]),
            .i_nq    (st_nq[g]),
            .i_den   (st_den[g]),
            .i_ctl   (st_ctl[g]),
            .o_valid (st_valid[g+1]),
            .o_rem   (st_rem[g+1]),
            .o_nq    (st_nq[g+1]),
            .o_den   (st_den[g+1]),
            .o_ctl   (st_ctl[g+1])
        );
    end

    rdiv_fix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (st_valid[DATA_WIDTH]),
        .i_quot      (st_nq[DATA_WIDTH]),
        .i_rem       (st_rem[DATA_WIDTH]),
        .i_ctl       (st_ctl[DATA_WIDTH]),
        .i_out_ready (o_out.ready),
        .o_en        (en),
        .o_out_valid (o_out.valid),
        .o_quotient  (o_out.quotient),
        .o_remainder (o_out.remainder)
    );

endmodule

`default_nettype wire

FILE: rtl/rdiv_chk.sv
// Checker of the divider's port behaviour over time, bound to the top level.
`default_nettype none

module rdiv_chk #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [DATA_WIDTH-1:0] i_quotient,
    input wire logic [DATA_WIDTH-1:0] i_remainder
);

    // A stalled result holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_quotient) && $stable(i_remainder)))
        else $error("stalled result changed or vanished");

    // Back-pressure on the input only follows a stalled output.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_out_valid && !i_out_ready))
        else $error("input ready dropped without an output stall");

    // With the skid register full the output register is full as well.
    a_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input refused while no result is waiting");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("pipeline not empty after reset");

    // An input valid seen during reset must not yield a result straight after it.
    a_reset_in: assert property (@(posedge i_clk)
        (!i_rst_n && i_in_valid) |=> !i_out_valid)
        else $error("result appeared straight out of reset");

endmodule

bind restoring_divider_signed_unsigned_top rdiv_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_rdiv_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_quotient  (o_out.quotient),
    .i_remainder (o_out.remainder)
);

`default_nettype wire
